@@ rtl/core/quadratic_root_solver_macros.svh @@
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion forms for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and widths for the pipelined quadratic root solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int W   = 32;          // coefficient / root width
  localparam int F   = 16;          // fraction bits
  localparam int DW  = 2 * W + 2;   // discriminant magnitude
  localparam int DW1 = DW + 1;
  localparam int SQ  = W + 1;       // square root bits
  localparam int MW  = W + 3;       // signed numerator width
  localparam int NW  = MW + F;      // dividend / quotient width
  localparam int DVW = W + 1;       // divisor magnitude width

  typedef enum logic [2:0] {
    ST_ONE_ROOT    = 3'd0,
    ST_TWO_ROOTS   = 3'd1,
    ST_NO_REAL     = 3'd2,
    ST_NO_SOLUTION = 3'd3,
    ST_ALL_REAL    = 3'd4
  } qrs_status_t;

  typedef struct packed {
    logic signed [W-1:0] coef_quad;
    logic signed [W-1:0] coef_lin;
    logic signed [W-1:0] coef_const;
  } qrs_in_t;

  typedef struct packed {
    qrs_status_t         status;
    logic signed [W-1:0] root_first;
    logic signed [W-1:0] root_second;
    logic                overflow;
  } qrs_out_t;

  // control carried down the front of the pipe
  typedef struct packed {
    logic signed [W:0] nb;    // numerator base
    logic signed [W:0] den;   // signed divisor
    logic              use1;
    logic              use2;
    logic              gen;   // general case, roots from sqrt
    qrs_status_t       status;
  } qrs_ctl_t;

  // control carried through the dividers
  typedef struct packed {
    logic        neg1;
    logic        neg2;
    logic        use1;
    logic        use2;
    qrs_status_t status;
  } qrs_dctl_t;

endpackage

@@ rtl/core/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Channel | Signals                    | Beat
// --------+----------------------------+--------------------------------
// coef    | coef_valid coef_ready coef | a, b, c (signed Q16.16)
// root    | root_valid root_ready root | status, two roots, overflow
//
// One beat in per cycle while the pipe is not stalled, one result per beat.
// Stages: input, products, discriminant, 33 square root stages, numerator,
// 51 divider stages, saturation, output register. Two dividers run side by side.
// A two-entry output buffer (register plus skid) lets the pipe keep taking
// beats while a result waits; the pipe stalls only when the skid is full.
// Reset clears the valid bits, including those of the output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver (
  input  logic              clk,
  input  logic              rst,
  input  logic              coef_valid,
  output logic              coef_ready,
  input  qrs_pkg::qrs_in_t  coef,
  output logic              root_valid,
  input  logic              root_ready,
  output qrs_pkg::qrs_out_t root
);
  import qrs_pkg::*;

  localparam int S_SQ0 = 3;
  localparam int S_NUM = S_SQ0 + SQ;
  localparam int S_DV0 = S_NUM + 1;
  localparam int NS    = S_DV0 + NW + 1;

  typedef struct packed {
    logic signed [W-1:0] val;
    logic                ovf;
  } sat_t;

  function automatic sat_t saturate(input logic [NW-1:0] q, input logic neg,
                                    input logic en_root);
    logic [NW-1:0] lim;
    logic [NW-1:0] qs;
    sat_t          r;
    lim   = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
    qs    = (q > lim) ? lim : q;
    r.ovf = en_root && (q > lim);
    r.val = en_root ? (neg ? -qs[W-1:0] : qs[W-1:0]) : '0;
    return r;
  endfunction

  logic [NS-1:0] v;
  logic          en;
  logic          out_v, skid_v;
  qrs_out_t      out_d, skid_d;

  assign en         = !skid_v;
  assign coef_ready = en;
  assign root_valid = out_v;
  assign root       = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], coef_valid};
    end
  end

  // stage 0: input register
  qrs_in_t in_q;
  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= coef;
    end
  end

  // stage 1: case decode and products
  logic [W-1:0]   ma, mb, mc;
  qrs_ctl_t       ctl_c;
  logic [2*W-1:0] mul_bb, mul_ac;
  logic           mul_sd;
  qrs_ctl_t       mul_ctl;

  always_comb begin
    ma = in_q.coef_quad[W-1]  ? (~in_q.coef_quad + 1'b1)  : in_q.coef_quad;
    mb = in_q.coef_lin[W-1]   ? (~in_q.coef_lin + 1'b1)   : in_q.coef_lin;
    mc = in_q.coef_const[W-1] ? (~in_q.coef_const + 1'b1) : in_q.coef_const;
    ctl_c        = '0;
    ctl_c.status = ST_ONE_ROOT;
    ctl_c.nb     = -{in_q.coef_lin[W-1], in_q.coef_lin};
    if (in_q.coef_quad == '0) begin
      if (in_q.coef_lin != '0) begin
        ctl_c.nb   = -{in_q.coef_const[W-1], in_q.coef_const};
        ctl_c.den  = {in_q.coef_lin[W-1], in_q.coef_lin};
        ctl_c.use1 = 1'b1;
      end else begin
        ctl_c.status = (in_q.coef_const == '0) ? ST_ALL_REAL : ST_NO_SOLUTION;
      end
    end else if (in_q.coef_const == '0) begin
      // roots 0 and -b/a, or 0 alone
      if (in_q.coef_lin != '0) begin
        ctl_c.status = ST_TWO_ROOTS;
        ctl_c.den    = {in_q.coef_quad[W-1], in_q.coef_quad};
        ctl_c.use2   = 1'b1;
      end
    end else begin
      ctl_c.den = {in_q.coef_quad, 1'b0};
      ctl_c.gen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_bb  <= mb * mb;
      mul_ac  <= ma * mc;
      mul_sd  <= in_q.coef_quad[W-1] ^ in_q.coef_const[W-1];
      mul_ctl <= ctl_c;
    end
  end

  // stage 2: discriminant magnitude
  logic [DW-1:0] sq_rem [0:SQ];
  logic [SQ-1:0] sq_res [0:SQ];
  qrs_ctl_t      sq_ctl [0:SQ];
  logic [DW-1:0] bbx, ac4, disc;
  qrs_ctl_t      dctl;

  always_comb begin
    bbx  = {2'b00, mul_bb};
    ac4  = {mul_ac, 2'b00};
    dctl = mul_ctl;
    disc = '0;
    if (mul_ctl.gen) begin
      if (mul_sd) begin
        disc = bbx + ac4;
      end else if (bbx >= ac4) begin
        disc = bbx - ac4;
      end else begin
        dctl.gen    = 1'b0;
        dctl.status = ST_NO_REAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= disc;
      sq_res[0] <= '0;
      sq_ctl[0] <= dctl;
    end
  end

  // square root, one result bit per stage, most significant first
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int I = SQ - 1 - j;
    logic [DW:0] trial, rem_x;
    logic        take;
    always_comb begin
      trial = (DW1'(sq_res[j]) << (I + 1)) + (DW1'(1) << (2 * I));
      rem_x = {1'b0, sq_rem[j]};
      take  = rem_x >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[j+1] <= take ? DW'(rem_x - trial) : sq_rem[j];
        sq_res[j+1] <= take ? (sq_res[j] | (SQ'(1) << I)) : sq_res[j];
        sq_ctl[j+1] <= sq_ctl[j];
      end
    end
  end

  // numerator stage: -b -/+ sqrt d, magnitudes and signs
  logic [NW-1:0]     dv_nq1 [0:NW];
  logic [NW-1:0]     dv_nq2 [0:NW];
  logic [DVW-1:0]    dv_rem1 [0:NW];
  logic [DVW-1:0]    dv_rem2 [0:NW];
  logic [DVW-1:0]    dv_dv  [0:NW];
  qrs_dctl_t         dv_ctl [0:NW];
  logic signed [MW-1:0] nbx, sx, num1, num2;
  logic [MW-1:0]     m1, m2;
  logic [DVW-1:0]    dm;
  qrs_dctl_t         nctl;
  qrs_ctl_t          sc;

  always_comb begin
    sc   = sq_ctl[SQ];
    nbx  = {{(MW - W - 1){sc.nb[W]}}, sc.nb};
    sx   = {{(MW - SQ){1'b0}}, sq_res[SQ]};
    num1 = nbx - sx;
    num2 = nbx + sx;
    m1   = num1[MW-1] ? (~num1 + 1'b1) : num1;
    m2   = num2[MW-1] ? (~num2 + 1'b1) : num2;
    dm   = sc.den[W] ? (~sc.den + 1'b1) : sc.den;
    nctl.neg1   = num1[MW-1] ^ sc.den[W];
    nctl.neg2   = num2[MW-1] ^ sc.den[W];
    nctl.use1   = sc.use1;
    nctl.use2   = sc.use2;
    nctl.status = sc.status;
    if (sc.gen) begin
      // a zero root means d was zero: single root
      nctl.use1   = 1'b1;
      nctl.use2   = sq_res[SQ] != '0;
      nctl.status = (sq_res[SQ] != '0) ? ST_TWO_ROOTS : ST_ONE_ROOT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_nq1[0]  <= {m1, {F{1'b0}}};
      dv_nq2[0]  <= {m2, {F{1'b0}}};
      dv_rem1[0] <= '0;
      dv_rem2[0] <= '0;
      dv_dv[0]   <= dm;
      dv_ctl[0]  <= nctl;
    end
  end

  // restoring dividers: dividend shifts out at the top, quotient in at the bottom
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DVW:0] t1, t2;
    logic         ge1, ge2;
    always_comb begin
      t1  = {dv_rem1[j], dv_nq1[j][NW-1]};
      t2  = {dv_rem2[j], dv_nq2[j][NW-1]};
      ge1 = t1 >= {1'b0, dv_dv[j]};
      ge2 = t2 >= {1'b0, dv_dv[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem1[j+1] <= ge1 ? DVW'(t1 - {1'b0, dv_dv[j]}) : t1[DVW-1:0];
        dv_rem2[j+1] <= ge2 ? DVW'(t2 - {1'b0, dv_dv[j]}) : t2[DVW-1:0];
        dv_nq1[j+1]  <= {dv_nq1[j][NW-2:0], ge1};
        dv_nq2[j+1]  <= {dv_nq2[j][NW-2:0], ge2};
        dv_dv[j+1]   <= dv_dv[j];
        dv_ctl[j+1]  <= dv_ctl[j];
      end
    end
  end

  // saturation stage
  sat_t      s1, s2;
  qrs_out_t  res_c, res_q;
  qrs_dctl_t fc;

  always_comb begin
    fc = dv_ctl[NW];
    s1 = saturate(dv_nq1[NW], fc.neg1, fc.use1);
    s2 = saturate(dv_nq2[NW], fc.neg2, fc.use2);
    res_c.status      = fc.status;
    res_c.root_first  = s1.val;
    res_c.root_second = s2.val;
    res_c.overflow    = s1.ovf | s2.ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res_c;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (root_ready) begin
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end
    end else if (v[NS-1]) begin
      if (!out_v || root_ready) begin
        out_v <= 1'b1;
        out_d <= res_q;
      end else begin
        skid_v <= 1'b1;
        skid_d <= res_q;
      end
    end else if (root_ready) begin
      out_v <= 1'b0;
    end
  end

  `QRS_ASSERT_NOW(a_skid_needs_out, clk, rst, skid_v, out_v, "skid holds a beat with output empty")
  `QRS_ASSERT_NEXT(a_skid_holds, clk, rst, skid_v && !root_ready, skid_v, "skid beat lost")
  `QRS_ASSERT_NEXT(a_last_lands, clk, rst, v[NS-1] && en, out_v, "pipe beat dropped at output")
  `QRS_ASSERT_NOW(a_no_root_zero, clk, rst, out_v && (out_d.status == ST_NO_REAL || out_d.status == ST_NO_SOLUTION || out_d.status == ST_ALL_REAL), out_d.root_first == '0 && !out_d.overflow, "root reported without a solution")
  `QRS_ASSERT_NOW(a_second_only_two, clk, rst, out_v && out_d.status != ST_TWO_ROOTS, out_d.root_second == '0, "second root without two roots")

endmodule
